### hw/rtl/assert_macros.svh
// Assertion helpers for the scheduler RTL (included by spts_ctrl).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// antecedent holds -> consequent holds in the same cycle
`define SPTS_ASSERT_SAME(lbl, c, r, a, b, msg) \
    lbl: assert property (@(posedge c) disable iff (!r) (a) |-> (b)) else $error(msg);
// antecedent holds -> consequent holds in the following cycle
`define SPTS_ASSERT_NEXT(lbl, c, r, a, b, msg) \
    lbl: assert property (@(posedge c) disable iff (!r) (a) |=> (b)) else $error(msg);
`else
`define SPTS_ASSERT_SAME(lbl, c, r, a, b, msg)
`define SPTS_ASSERT_NEXT(lbl, c, r, a, b, msg)
`endif
`endif

### hw/rtl/spts_pkg.sv
package spts_pkg;

    localparam int NUM_LEVELS_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int ACT_W  = 2;
    localparam int ID_W   = 6;
    localparam int PRIO_W = 3;

    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = ACT_W;
    localparam int OUT_TDATA_W = 16;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD   = 2'd0,
        ACT_BLOCK = 2'd1,
        ACT_SLICE = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH_RD,
        ST_PUSH_WR,
        ST_DISP_RD,
        ST_DISP_POP,
        ST_DISP_LOAD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic            dropped;
        logic            switched;
        logic            idle;
        logic [ID_W-1:0] running_task;
    } result_t;

endpackage

### hw/rtl/spts_queue_mem.sv
// Ready-queue store: one ring of task ids per level, addressed {level, slot}.
module spts_queue_mem #(
    parameter int ADDR_W = 7
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [ADDR_W-1:0]         waddr,
    input  logic [spts_pkg::ID_W-1:0] wdata,
    input  logic                      re,
    input  logic [ADDR_W-1:0]         raddr,
    output logic [spts_pkg::ID_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [spts_pkg::ID_W-1:0] mem [DEPTH];
    logic [spts_pkg::ID_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/spts_level_mem.sv
// Per-level descriptor store {head, tail, count}; an entry never written reads as zero.
module spts_level_mem #(
    parameter int NUM_LEVELS = spts_pkg::NUM_LEVELS_DEF,
    parameter int ENTRY_W    = 13
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          we,
    input  logic [$clog2(NUM_LEVELS)-1:0] waddr,
    input  logic [ENTRY_W-1:0]            wdata,
    input  logic                          re,
    input  logic [$clog2(NUM_LEVELS)-1:0] raddr,
    output logic [ENTRY_W-1:0]            rdata
);

    logic [ENTRY_W-1:0]    mem [NUM_LEVELS];
    logic [ENTRY_W-1:0]    rdata_reg;
    logic [NUM_LEVELS-1:0] valid_reg;
    logic                  rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rd_valid_reg <= valid_reg[raddr];
            end
        end
    end

    assign rdata = rd_valid_reg ? rdata_reg : '0;

endmodule

### hw/rtl/spts_ctrl.sv
// Event sequencer: read-modify-write of the level descriptors and the queue store.
`include "assert_macros.svh"

module spts_ctrl #(
    parameter int NUM_LEVELS  = spts_pkg::NUM_LEVELS_DEF,
    parameter int QUEUE_DEPTH = spts_pkg::QUEUE_DEPTH_DEF,
    parameter int LVL_W       = $clog2(NUM_LEVELS),
    parameter int PTR_W       = $clog2(QUEUE_DEPTH),
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1),
    parameter int ENTRY_W     = 2 * PTR_W + CNT_W
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // event side
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [spts_pkg::ACT_W-1:0]   action,
    input  logic [spts_pkg::ID_W-1:0]    task_id,
    input  logic [spts_pkg::PRIO_W-1:0]  priority_req,
    // result side
    output logic                         res_valid,
    input  logic                         res_ready,
    output spts_pkg::result_t            res,
    // level descriptor store
    output logic                         lm_we,
    output logic [LVL_W-1:0]             lm_waddr,
    output logic [ENTRY_W-1:0]           lm_wdata,
    output logic                         lm_re,
    output logic [LVL_W-1:0]             lm_raddr,
    input  logic [ENTRY_W-1:0]           lm_rdata,
    // queue store
    output logic                         qm_we,
    output logic [LVL_W+PTR_W-1:0]       qm_waddr,
    output logic [spts_pkg::ID_W-1:0]    qm_wdata,
    output logic                         qm_re,
    output logic [LVL_W+PTR_W-1:0]       qm_raddr,
    input  logic [spts_pkg::ID_W-1:0]    qm_rdata
);

    localparam int SAT_W = (LVL_W > spts_pkg::PRIO_W) ? LVL_W : spts_pkg::PRIO_W;
    localparam logic [SAT_W-1:0] TOP_LVL   = SAT_W'(NUM_LEVELS - 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

    spts_pkg::state_t state_reg, state_next;

    logic [spts_pkg::ID_W-1:0] id_reg, id_next;
    logic [LVL_W-1:0]          lvl_reg, lvl_next;
    logic                      sel_cur_reg, sel_cur_next;
    logic [spts_pkg::ID_W-1:0] cur_id_reg, cur_id_next;
    logic [LVL_W-1:0]          cur_lvl_reg, cur_lvl_next;
    logic                      running_reg, running_next;
    logic                      switched_reg, switched_next;
    logic                      dropped_reg, dropped_next;
    logic [NUM_LEVELS-1:0]     nonempty_reg, nonempty_next;
    logic [LVL_W-1:0]          disp_lvl_reg, disp_lvl_next;

    logic [SAT_W-1:0]          req_ext;
    logic [LVL_W-1:0]          req_lvl;
    logic [LVL_W-1:0]          top_lvl;
    logic [PTR_W-1:0]          rd_head;
    logic [PTR_W-1:0]          rd_tail;
    logic [CNT_W-1:0]          rd_count;
    logic [PTR_W-1:0]          head_inc;
    logic [PTR_W-1:0]          tail_inc;
    logic                      lvl_full;
    logic [LVL_W-1:0]          push_lvl;
    logic [spts_pkg::ID_W-1:0] push_id;

    // saturate the requested level to the top implemented level
    assign req_ext = SAT_W'(priority_req);
    always_comb
    begin
        if (req_ext > TOP_LVL)
        begin
            req_lvl = TOP_LVL[LVL_W-1:0];
        end
        else
        begin
            req_lvl = req_ext[LVL_W-1:0];
        end
    end

    // highest non-empty level; later (higher) indexes win
    always_comb
    begin
        top_lvl = '0;
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            if (nonempty_reg[i])
            begin
                top_lvl = LVL_W'(i);
            end
        end
    end

    assign rd_head  = lm_rdata[ENTRY_W-1 -: PTR_W];
    assign rd_tail  = lm_rdata[CNT_W+PTR_W-1 -: PTR_W];
    assign rd_count = lm_rdata[CNT_W-1:0];
    assign head_inc = (rd_head == LAST_SLOT) ? '0 : rd_head + 1'b1;
    assign tail_inc = (rd_tail == LAST_SLOT) ? '0 : rd_tail + 1'b1;
    assign lvl_full = (rd_count >= FULL_CNT);
    assign push_lvl = sel_cur_reg ? cur_lvl_reg : lvl_reg;
    assign push_id  = sel_cur_reg ? cur_id_reg : id_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= spts_pkg::ST_IDLE;
            sel_cur_reg  <= 1'b0;
            cur_id_reg   <= '0;
            cur_lvl_reg  <= '0;
            running_reg  <= 1'b0;
            switched_reg <= 1'b0;
            dropped_reg  <= 1'b0;
            nonempty_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            sel_cur_reg  <= sel_cur_next;
            cur_id_reg   <= cur_id_next;
            cur_lvl_reg  <= cur_lvl_next;
            running_reg  <= running_next;
            switched_reg <= switched_next;
            dropped_reg  <= dropped_next;
            nonempty_reg <= nonempty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg       <= id_next;
        lvl_reg      <= lvl_next;
        disp_lvl_reg <= disp_lvl_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        id_next       = id_reg;
        lvl_next      = lvl_reg;
        sel_cur_next  = sel_cur_reg;
        cur_id_next   = cur_id_reg;
        cur_lvl_next  = cur_lvl_reg;
        running_next  = running_reg;
        switched_next = switched_reg;
        dropped_next  = dropped_reg;
        nonempty_next = nonempty_reg;
        disp_lvl_next = disp_lvl_reg;

        in_ready  = 1'b0;
        res_valid = 1'b0;
        lm_we     = 1'b0;
        lm_waddr  = push_lvl;
        lm_wdata  = {rd_head, tail_inc, rd_count + 1'b1};
        lm_re     = 1'b0;
        lm_raddr  = push_lvl;
        qm_we     = 1'b0;
        qm_waddr  = {push_lvl, rd_tail};
        qm_wdata  = push_id;
        qm_re     = 1'b0;
        qm_raddr  = {disp_lvl_reg, rd_head};

        unique case (state_reg)
            spts_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    id_next       = task_id;
                    lvl_next      = req_lvl;
                    sel_cur_next  = 1'b0;
                    switched_next = 1'b0;
                    dropped_next  = 1'b0;
                    unique case (spts_pkg::action_t'(action))
                        spts_pkg::ACT_ADD:
                        begin
                            state_next = spts_pkg::ST_PUSH_RD;
                        end
                        spts_pkg::ACT_BLOCK:
                        begin
                            state_next = spts_pkg::ST_DISP_RD;
                        end
                        spts_pkg::ACT_SLICE:
                        begin
                            // requeue the running task first, if any
                            sel_cur_next = running_reg;
                            state_next   = running_reg ? spts_pkg::ST_PUSH_RD
                                                       : spts_pkg::ST_DISP_RD;
                        end
                        default:
                        begin
                            state_next = spts_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            spts_pkg::ST_PUSH_RD:
            begin
                lm_re      = 1'b1;
                state_next = spts_pkg::ST_PUSH_WR;
            end

            spts_pkg::ST_PUSH_WR:
            begin
                if (lvl_full)
                begin
                    dropped_next = 1'b1;
                end
                else
                begin
                    lm_we                   = 1'b1;
                    qm_we                   = 1'b1;
                    nonempty_next[push_lvl] = 1'b1;
                end
                if (sel_cur_reg)
                begin
                    state_next = spts_pkg::ST_DISP_RD;
                end
                else if (lvl_full)
                begin
                    state_next = spts_pkg::ST_DONE;
                end
                else if (!running_reg || (lvl_reg > cur_lvl_reg))
                begin
                    // preempt: requeue the running task, then dispatch
                    sel_cur_next = running_reg;
                    state_next   = running_reg ? spts_pkg::ST_PUSH_RD
                                               : spts_pkg::ST_DISP_RD;
                end
                else
                begin
                    state_next = spts_pkg::ST_DONE;
                end
            end

            spts_pkg::ST_DISP_RD:
            begin
                if (nonempty_reg == '0)
                begin
                    cur_id_next   = '0;
                    cur_lvl_next  = '0;
                    running_next  = 1'b0;
                    switched_next = 1'b1;
                    state_next    = spts_pkg::ST_DONE;
                end
                else
                begin
                    disp_lvl_next = top_lvl;
                    lm_re         = 1'b1;
                    lm_raddr      = top_lvl;
                    state_next    = spts_pkg::ST_DISP_POP;
                end
            end

            spts_pkg::ST_DISP_POP:
            begin
                qm_re    = 1'b1;
                lm_we    = 1'b1;
                lm_waddr = disp_lvl_reg;
                lm_wdata = {head_inc, rd_tail, rd_count - 1'b1};
                if (rd_count == CNT_W'(1))
                begin
                    nonempty_next[disp_lvl_reg] = 1'b0;
                end
                state_next = spts_pkg::ST_DISP_LOAD;
            end

            spts_pkg::ST_DISP_LOAD:
            begin
                cur_id_next   = qm_rdata;
                cur_lvl_next  = disp_lvl_reg;
                running_next  = 1'b1;
                switched_next = 1'b1;
                state_next    = spts_pkg::ST_DONE;
            end

            spts_pkg::ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = spts_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = spts_pkg::ST_IDLE;
            end
        endcase
    end

    assign res.running_task = running_reg ? cur_id_reg : '0;
    assign res.idle         = !running_reg;
    assign res.switched     = switched_reg;
    assign res.dropped      = dropped_reg;

    `SPTS_ASSERT_SAME(a_idle_id_zero, clk, rst_n, !running_reg, cur_id_reg == '0, "idle with nonzero task id")
    `SPTS_ASSERT_SAME(a_pop_nonempty, clk, rst_n, state_reg == spts_pkg::ST_DISP_POP, rd_count != '0, "dispatch from empty level")
    `SPTS_ASSERT_SAME(a_requeue_running, clk, rst_n, state_reg == spts_pkg::ST_PUSH_WR && sel_cur_reg, running_reg, "requeue while idle")
    `SPTS_ASSERT_NEXT(a_load_runs, clk, rst_n, state_reg == spts_pkg::ST_DISP_LOAD, running_reg && switched_reg, "dispatch did not start task")

endmodule

### hw/rtl/static_priority_task_scheduler_core.sv
// Static priority task scheduler. One FIFO of task ids per priority level (larger level is
// higher priority) plus the running task. Each input transaction is one event, selected by
// s_axis_tuser: add a task (enqueue, preempt when idle or at a higher level), block the
// running task (dispatch again), or time-slice expiry (requeue the running task at its level
// tail, then dispatch). Dispatch pops the head of the highest non-empty level, or goes idle.
// Every event, including the unused action code, returns exactly one result transaction.
// Events are handled one at a time by a sequencer over two single-port-per-direction
// memories with registered read data. Each queue push and each pop is a read-modify-write
// of the level descriptor store. The result sits in an output register, so a new event is
// taken while the previous result still waits on m_axis_tready. No clearing pass after
// reset: level descriptors carry per-level valid bits.
module static_priority_task_scheduler_core #(
    parameter int NUM_LEVELS  = spts_pkg::NUM_LEVELS_DEF,
    parameter int QUEUE_DEPTH = spts_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // event input
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [5:0] task_id, [8:6] priority_req, [15:9] zero
    input  logic [spts_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [1:0] action
    input  logic [spts_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    // result output
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [5:0] running_task, [6] idle, [7] switched, [8] dropped, [15:9] zero
    output logic [spts_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

    localparam int LVL_W   = $clog2(NUM_LEVELS);
    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = 2 * PTR_W + CNT_W;
    localparam int QA_W    = LVL_W + PTR_W;
    localparam int RES_W   = $bits(spts_pkg::result_t);

    logic                      res_valid;
    logic                      res_ready;
    spts_pkg::result_t         res;

    logic                      lm_we;
    logic [LVL_W-1:0]          lm_waddr;
    logic [ENTRY_W-1:0]        lm_wdata;
    logic                      lm_re;
    logic [LVL_W-1:0]          lm_raddr;
    logic [ENTRY_W-1:0]        lm_rdata;

    logic                      qm_we;
    logic [QA_W-1:0]           qm_waddr;
    logic [spts_pkg::ID_W-1:0] qm_wdata;
    logic                      qm_re;
    logic [QA_W-1:0]           qm_raddr;
    logic [spts_pkg::ID_W-1:0] qm_rdata;

    logic                      out_valid_reg;
    spts_pkg::result_t         out_data_reg;

    spts_ctrl #(
        .NUM_LEVELS  (NUM_LEVELS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .LVL_W       (LVL_W),
        .PTR_W       (PTR_W),
        .CNT_W       (CNT_W),
        .ENTRY_W     (ENTRY_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .action       (s_axis_tuser[spts_pkg::ACT_W-1:0]),
        .task_id      (s_axis_tdata[spts_pkg::ID_W-1:0]),
        .priority_req (s_axis_tdata[spts_pkg::ID_W +: spts_pkg::PRIO_W]),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .lm_we        (lm_we),
        .lm_waddr     (lm_waddr),
        .lm_wdata     (lm_wdata),
        .lm_re        (lm_re),
        .lm_raddr     (lm_raddr),
        .lm_rdata     (lm_rdata),
        .qm_we        (qm_we),
        .qm_waddr     (qm_waddr),
        .qm_wdata     (qm_wdata),
        .qm_re        (qm_re),
        .qm_raddr     (qm_raddr),
        .qm_rdata     (qm_rdata)
    );

    // head/tail/count per level
    spts_level_mem #(
        .NUM_LEVELS (NUM_LEVELS),
        .ENTRY_W    (ENTRY_W)
    ) u_level_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (lm_we),
        .waddr (lm_waddr),
        .wdata (lm_wdata),
        .re    (lm_re),
        .raddr (lm_raddr),
        .rdata (lm_rdata)
    );

    // task id rings, {level, slot}
    spts_queue_mem #(
        .ADDR_W (QA_W)
    ) u_queue_mem (
        .clk   (clk),
        .we    (qm_we),
        .waddr (qm_waddr),
        .wdata (qm_wdata),
        .re    (qm_re),
        .raddr (qm_raddr),
        .rdata (qm_rdata)
    );

    // output register: the sequencer hands over a result whenever this slot is free
    // or is being emptied in the same cycle
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(spts_pkg::OUT_TDATA_W - RES_W){1'b0}}, out_data_reg};

endmodule

### verif/static_priority_task_scheduler_core_test.sv
module static_priority_task_scheduler_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import spts_pkg::*;

    localparam int LEVELS      = NUM_LEVELS_DEF;
    localparam int DEPTH       = QUEUE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_WAIT  = 20;

    // action code with no defined event; the block still answers it
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    typedef logic [ID_W-1:0]            task_t;
    typedef logic [PRIO_W-1:0]          level_t;
    typedef logic [$clog2(DEPTH)-1:0]   slot_t;
    typedef logic [$clog2(DEPTH):0]     fill_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        task_t            task_id;
        level_t           prio;
    } sched_event_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    static_priority_task_scheduler_core u_top (
        .clk,
        .rst_n,
        .s_axis_tvalid,
        .s_axis_tready,
        .s_axis_tdata,
        .s_axis_tuser,
        .m_axis_tvalid,
        .m_axis_tready,
        .m_axis_tdata
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Scheduler shadow state: ready FIFO per level plus the running task
    // ------------------------------------------------------------------
    task_t  ready_ids [LEVELS][DEPTH];
    slot_t  head_ptr  [LEVELS] = '{default: '0};
    slot_t  tail_ptr  [LEVELS] = '{default: '0};
    fill_t  ready_cnt [LEVELS] = '{default: '0};
    task_t  cur_task  = '0;
    level_t cur_level = '0;
    logic   has_task  = 1'b0;

    sched_event_t pending_events[$];
    result_t      results_due[$];
    int           events_total = 0;
    int           events_taken = 0;
    int           mismatches   = 0;
    int           cycle_count  = 0;
    int           src_hold     = 0;
    int           src_calm     = 0;
    int           sink_hold    = 0;
    int           sink_calm    = 0;
    sched_event_t in_flight;

    // returns 0 when the level is already full
    function automatic logic enqueue_ready(level_t lvl, task_t id);
        if (ready_cnt[lvl] >= DEPTH)
            return 1'b0;
        ready_ids[lvl][tail_ptr[lvl]] = id;
        tail_ptr[lvl] = slot_t'((int'(tail_ptr[lvl]) + 1) % DEPTH);
        ready_cnt[lvl]++;
        return 1'b1;
    endfunction

    // highest non-empty level wins; otherwise go idle
    function automatic void dispatch_next();
        for (int lvl = LEVELS - 1; lvl >= 0; lvl--) begin
            if (ready_cnt[lvl] != 0) begin
                cur_task      = ready_ids[lvl][head_ptr[lvl]];
                head_ptr[lvl] = slot_t'((int'(head_ptr[lvl]) + 1) % DEPTH);
                ready_cnt[lvl]--;
                cur_level     = level_t'(lvl);
                has_task      = 1'b1;
                return;
            end
        end
        cur_task  = '0;
        cur_level = '0;
        has_task  = 1'b0;
    endfunction

    // put the running task back at its level tail; 1 when it got lost
    function automatic logic requeue_running();
        if (!has_task)
            return 1'b0;
        return !enqueue_ready(cur_level, cur_task);
    endfunction

    function automatic result_t schedule_event(sched_event_t ev);
        level_t  lvl;
        result_t res;
        lvl = ev.prio;
        if (int'(lvl) > LEVELS - 1)
            lvl = level_t'(LEVELS - 1);
        res = '0;
        case (ev.action)
            ACT_ADD: begin
                if (!enqueue_ready(lvl, ev.task_id)) begin
                    res.dropped = 1'b1;
                end else if (!has_task || lvl > cur_level) begin
                    res.dropped  = requeue_running();
                    dispatch_next();
                    res.switched = 1'b1;
                end
            end
            ACT_BLOCK: begin
                dispatch_next();
                res.switched = 1'b1;
            end
            ACT_SLICE: begin
                res.dropped  = requeue_running();
                dispatch_next();
                res.switched = 1'b1;
            end
            default: ;
        endcase
        res.running_task = has_task ? cur_task : '0;
        res.idle         = !has_task;
        return res;
    endfunction

    function automatic void queue_event(logic [ACT_W-1:0] act, task_t id, level_t lvl);
        pending_events.push_back('{act, id, lvl});
    endfunction

    // mostly short gaps, a few long ones, and now and then a calm stretch
    function automatic int idle_len(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 31) == 0) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void flag_mismatch(string what, int want, int got);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
    endfunction

    // ------------------------------------------------------------------
    // Event driver: prediction is taken at the accepting edge
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin : drive_events
        logic                  accepted;
        logic [IN_TDATA_W-1:0] word;
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end else begin
            accepted = s_axis_tvalid && s_axis_tready;
            if (accepted) begin
                results_due.push_back(schedule_event(in_flight));
                events_taken++;
                src_hold = idle_len(src_calm);
            end
            if (accepted || !s_axis_tvalid) begin
                if (src_hold > 0) begin
                    src_hold--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_events.size() != 0) begin
                    in_flight = pending_events.pop_front();
                    word = '0;
                    word[ID_W-1:0]           = in_flight.task_id;
                    word[ID_W+PRIO_W-1:ID_W] = in_flight.prio;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= word;
                    s_axis_tuser  <= in_flight.action;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor with random back-pressure
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin : check_results
        result_t got;
        result_t want;
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[$bits(result_t)-1:0];
                if (results_due.size() == 0) begin
                    flag_mismatch("result transaction with nothing pending, tdata", -1,
                                  m_axis_tdata);
                end else begin
                    want = results_due.pop_front();
                    if (got.running_task !== want.running_task)
                        flag_mismatch("running_task", want.running_task, got.running_task);
                    if (got.idle !== want.idle)
                        flag_mismatch("idle", want.idle, got.idle);
                    if (got.switched !== want.switched)
                        flag_mismatch("switched", want.switched, got.switched);
                    if (got.dropped !== want.dropped)
                        flag_mismatch("dropped", want.dropped, got.dropped);
                end
                sink_hold = idle_len(sink_calm);
            end else if (sink_hold == 0 && $urandom_range(0, 15) == 0) begin
                sink_hold = idle_len(sink_calm);
            end
            if (sink_hold > 0) begin
                sink_hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin : run_test
        int chunk;
        int add_pct;
        int lo;
        int hi;
        int r;
        int n;

        // idle corner cases: block and slice with nothing to run, unused code
        queue_event(ACT_BLOCK, '0, '0);
        queue_event(ACT_SLICE, '1, '1);
        queue_event(ACT_UNUSED, '0, '0);
        // start from idle at the lowest level, then preempt from the top
        queue_event(ACT_ADD, 6'd63, 3'd0);
        queue_event(ACT_ADD, 6'd0, 3'd7);
        queue_event(ACT_SLICE, '0, '0);
        // fill level 3 underneath the running task, then overflow it
        for (int i = 1; i <= DEPTH; i++)
            queue_event(ACT_ADD, task_t'(i), 3'd3);
        queue_event(ACT_ADD, 6'd42, 3'd3);
        // block: level 3 head runs, one slot frees up
        queue_event(ACT_BLOCK, '0, '0);
        queue_event(ACT_ADD, 6'd21, 3'd3);
        // slice with own level full: running task is lost
        queue_event(ACT_SLICE, '0, '0);
        queue_event(ACT_ADD, 6'd22, 3'd3);
        // preemption whose requeue hits the full level
        queue_event(ACT_ADD, 6'd50, 3'd5);
        queue_event(ACT_UNUSED, '1, '1);

        // random phases: add-heavy phases on a narrow band of levels fill queues
        // and overflow them, block-heavy phases drain down to idle
        n = 0;
        while (n < 1450) begin
            chunk = $urandom_range(20, 60);
            r = $urandom_range(0, 2);
            add_pct = (r == 0) ? 35 : (r == 1) ? 65 : 90;
            if ($urandom_range(0, 1) == 1) begin
                lo = $urandom_range(0, LEVELS - 1);
                hi = (lo + 1 > LEVELS - 1) ? LEVELS - 1 : lo + 1;
            end else begin
                lo = 0;
                hi = LEVELS - 1;
            end
            for (int i = 0; i < chunk; i++) begin
                r = $urandom_range(0, 99);
                if (r < 2)
                    queue_event(ACT_UNUSED, task_t'($urandom), level_t'($urandom));
                else if (r < add_pct)
                    queue_event(ACT_ADD, task_t'($urandom), level_t'($urandom_range(lo, hi)));
                else if (r % 2 == 0)
                    queue_event(ACT_BLOCK, task_t'($urandom), level_t'($urandom));
                else
                    queue_event(ACT_SLICE, task_t'($urandom), level_t'($urandom));
            end
            n += chunk;
        end
        events_total = pending_events.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (events_taken < events_total || results_due.size() != 0)
            @(negedge clk);
        // catch any stray result after the last expected one
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0 && results_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
